// File: hw/rtl/idnr_pkg.sv
// Shared types, constants and register codes for the binary64 normalize-and-round pipeline.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package idnr_pkg;

  localparam int FRACTION_BITS_DEF = 52;
  localparam int ROUND_BITS_DEF    = 8;
  localparam int MAX_EXPONENT_DEF  = 2046;

  // Fixed field widths.
  localparam int EXP_IN_W  = 14;
  localparam int EXP_OUT_W = 11;
  localparam int EXP_S_W   = 15;  // signed working exponent
  localparam int EXP_U_W   = 14;  // exponent once it is known to be non-negative
  localparam int CFG_W     = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROUND_MODE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UNDERFLOW_MODE = 1'b1;

  typedef enum logic [CFG_W-1:0] {
    RM_NEAREST_EVEN,
    RM_TOWARD_POS,
    RM_TOWARD_NEG,
    RM_TOWARD_ZERO
  } round_mode_t;

  typedef enum logic [CFG_W-1:0] {
    UF_KEEP,
    UF_FLUSH_SIGNED,
    UF_FLUSH_POS,
    UF_SIGNED_TINY
  } underflow_mode_t;

  // Control that travels with an item from stage to stage.
  typedef struct packed {
    logic sign;
    logic is_zero;
  } idnr_ctl_t;

  typedef struct packed {
    logic negative;
    logic zero;
    logic underflow;
    logic overflow;
    logic inexact;
  } idnr_flags_t;

endpackage

`default_nettype wire

// File: hw/rtl/ieee_double_normalize_round.sv
// Throughput: one item per cycle while out_stall is low; the four register stages
// (leading-one search, shift planning, barrel shift, round and pack) stall as a chain.
// Reset clears every stage valid bit and sets both mode registers to zero.
// Top level of the binary64 normalize-and-round pipeline; uses idnr_pkg and the
// idnr_lzc, idnr_plan, idnr_shift and idnr_round stages.
`default_nettype none

module ieee_double_normalize_round #(
  parameter int FRACTION_BITS = idnr_pkg::FRACTION_BITS_DEF,
  parameter int ROUND_BITS    = idnr_pkg::ROUND_BITS_DEF,
  parameter int MAX_EXPONENT  = idnr_pkg::MAX_EXPONENT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [idnr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [idnr_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 sign_in,
  input  logic signed [idnr_pkg::EXP_IN_W-1:0] exponent_in,
  input  logic [1:0]                           lead_bits,
  input  logic [FRACTION_BITS-1:0]             fraction_in,
  input  logic [ROUND_BITS-1:0]                round_bits,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 sign_out,
  output logic [idnr_pkg::EXP_OUT_W-1:0]       exponent_out,
  output logic [FRACTION_BITS-1:0]             fraction_out,
  output logic                                 flag_negative,
  output logic                                 flag_zero,
  output logic                                 flag_underflow,
  output logic                                 flag_overflow,
  output logic                                 flag_inexact
);
  import idnr_pkg::*;

  localparam int LOW_W  = FRACTION_BITS + ROUND_BITS;
  localparam int MAG_W  = LOW_W + 2;
  localparam int NEED_W = $clog2(LOW_W + 1);
  localparam int SHW    = $clog2(MAG_W + 1);

  round_mode_t     round_mode;
  underflow_mode_t underflow_mode;

  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_adv, s2_adv, s3_adv, s4_adv;

  idnr_ctl_t                  s1_ctl;
  logic signed [EXP_IN_W-1:0] s1_expo;
  logic [1:0]                 s1_lead;
  logic [LOW_W-1:0]           s1_low;
  logic [NEED_W-1:0]          s1_need;

  idnr_ctl_t                  s2_ctl;
  logic [EXP_U_W-1:0]         s2_expo;
  logic [MAG_W-1:0]           s2_mag;
  logic                       s2_shl;
  logic [SHW-1:0]             s2_amt;

  idnr_ctl_t                  s3_ctl;
  logic [EXP_U_W-1:0]         s3_expo;
  logic [1:0]                 s3_lead;
  logic [FRACTION_BITS-1:0]   s3_frac;
  logic [ROUND_BITS-1:0]      s3_rnd;

  idnr_flags_t                flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      round_mode     <= RM_NEAREST_EVEN;
      underflow_mode <= UF_KEEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROUND_MODE:     round_mode     <= round_mode_t'(cfg_data);
        REG_UNDERFLOW_MODE: underflow_mode <= underflow_mode_t'(cfg_data);
      endcase
    end
  end

  // A stage takes new data when it is empty or its item moves on this cycle.
  assign s4_adv   = !s4_valid || !out_stall;
  assign s3_adv   = !s3_valid || s4_adv;
  assign s2_adv   = !s2_valid || s3_adv;
  assign s1_adv   = !s1_valid || s2_adv;
  assign in_stall = !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= in_valid;
      end
      if (s2_adv) begin
        s2_valid <= s1_valid;
      end
      if (s3_adv) begin
        s3_valid <= s2_valid;
      end
      if (s4_adv) begin
        s4_valid <= s3_valid;
      end
    end
  end

  idnr_lzc #(
    .FRACTION_BITS(FRACTION_BITS),
    .ROUND_BITS   (ROUND_BITS)
  ) u_lzc (
    .clk        (clk),
    .en         (s1_adv),
    .sign_in    (sign_in),
    .exponent_in(exponent_in),
    .lead_bits  (lead_bits),
    .fraction_in(fraction_in),
    .round_bits (round_bits),
    .ctl        (s1_ctl),
    .expo       (s1_expo),
    .lead       (s1_lead),
    .low        (s1_low),
    .need       (s1_need)
  );

  idnr_plan #(
    .FRACTION_BITS(FRACTION_BITS),
    .ROUND_BITS   (ROUND_BITS)
  ) u_plan (
    .clk    (clk),
    .en     (s2_adv),
    .ctl_in (s1_ctl),
    .expo_in(s1_expo),
    .lead_in(s1_lead),
    .low_in (s1_low),
    .need_in(s1_need),
    .ctl    (s2_ctl),
    .expo   (s2_expo),
    .mag    (s2_mag),
    .shl    (s2_shl),
    .amt    (s2_amt)
  );

  idnr_shift #(
    .FRACTION_BITS(FRACTION_BITS),
    .ROUND_BITS   (ROUND_BITS)
  ) u_shift (
    .clk    (clk),
    .en     (s3_adv),
    .ctl_in (s2_ctl),
    .expo_in(s2_expo),
    .mag_in (s2_mag),
    .shl_in (s2_shl),
    .amt_in (s2_amt),
    .ctl    (s3_ctl),
    .expo   (s3_expo),
    .lead   (s3_lead),
    .frac   (s3_frac),
    .rnd    (s3_rnd)
  );

  idnr_round #(
    .FRACTION_BITS(FRACTION_BITS),
    .ROUND_BITS   (ROUND_BITS),
    .MAX_EXPONENT (MAX_EXPONENT)
  ) u_round (
    .clk           (clk),
    .en            (s4_adv),
    .round_mode    (round_mode),
    .underflow_mode(underflow_mode),
    .ctl_in        (s3_ctl),
    .expo_in       (s3_expo),
    .lead_in       (s3_lead),
    .frac_in       (s3_frac),
    .rnd_in        (s3_rnd),
    .sign_out      (sign_out),
    .exponent_out  (exponent_out),
    .fraction_out  (fraction_out),
    .flags         (flags)
  );

  assign out_valid      = s4_valid;
  assign flag_negative  = flags.negative;
  assign flag_zero      = flags.zero;
  assign flag_underflow = flags.underflow;
  assign flag_overflow  = flags.overflow;
  assign flag_inexact   = flags.inexact;

endmodule

`default_nettype wire

// File: hw/rtl/idnr_lzc.sv
// Stage 1: registers the input item, detects a zero magnitude and finds the distance
// from the leading one of the fraction and round bits to the integer position. Uses idnr_pkg.
`default_nettype none

module idnr_lzc #(
  parameter int FRACTION_BITS = idnr_pkg::FRACTION_BITS_DEF,
  parameter int ROUND_BITS    = idnr_pkg::ROUND_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic                                sign_in,
  input  logic signed [idnr_pkg::EXP_IN_W-1:0] exponent_in,
  input  logic [1:0]                          lead_bits,
  input  logic [FRACTION_BITS-1:0]            fraction_in,
  input  logic [ROUND_BITS-1:0]               round_bits,
  output idnr_pkg::idnr_ctl_t                 ctl,
  output logic signed [idnr_pkg::EXP_IN_W-1:0] expo,
  output logic [1:0]                          lead,
  output logic [FRACTION_BITS+ROUND_BITS-1:0] low,
  output logic [$clog2(FRACTION_BITS+ROUND_BITS+1)-1:0] need
);
  import idnr_pkg::*;

  localparam int LOW_W  = FRACTION_BITS + ROUND_BITS;
  localparam int POS_W  = $clog2(LOW_W);
  localparam int NEED_W = $clog2(LOW_W + 1);

  logic [LOW_W-1:0]  low_in;
  logic [POS_W-1:0]  pos;
  logic [NEED_W-1:0] need_next;

  assign low_in = {fraction_in, round_bits};

  // Priority encoder: the highest set bit wins.
  always_comb begin
    pos = '0;
    for (int i = 0; i < LOW_W; i++) begin
      if (low_in[i]) begin
        pos = POS_W'(i);
      end
    end
    need_next = NEED_W'(LOW_W) - NEED_W'(pos);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.sign    <= sign_in;
      ctl.is_zero <= (lead_bits == 2'd0) && !(|low_in);
      expo        <= exponent_in;
      lead        <= lead_bits;
      low         <= low_in;
      need        <= need_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/idnr_plan.sv
// Stage 2: decides the shift direction and amount and the exponent after alignment.
// Uses idnr_pkg.
`default_nettype none

module idnr_plan #(
  parameter int FRACTION_BITS = idnr_pkg::FRACTION_BITS_DEF,
  parameter int ROUND_BITS    = idnr_pkg::ROUND_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  idnr_pkg::idnr_ctl_t                  ctl_in,
  input  logic signed [idnr_pkg::EXP_IN_W-1:0] expo_in,
  input  logic [1:0]                           lead_in,
  input  logic [FRACTION_BITS+ROUND_BITS-1:0]  low_in,
  input  logic [$clog2(FRACTION_BITS+ROUND_BITS+1)-1:0] need_in,
  output idnr_pkg::idnr_ctl_t                  ctl,
  output logic [idnr_pkg::EXP_U_W-1:0]         expo,
  output logic [FRACTION_BITS+ROUND_BITS+1:0]  mag,
  output logic                                 shl,
  output logic [$clog2(FRACTION_BITS+ROUND_BITS+3)-1:0] amt
);
  import idnr_pkg::*;

  localparam int MAG_W  = FRACTION_BITS + ROUND_BITS + 2;
  localparam int SHW    = $clog2(MAG_W + 1);
  localparam logic signed [EXP_S_W-1:0] ONE   = 1;
  localparam logic signed [EXP_S_W-1:0] ZERO  = 0;
  localparam logic signed [EXP_S_W-1:0] MAG_X = EXP_S_W'(MAG_W);

  logic signed [EXP_S_W-1:0] expo_s;
  logic signed [EXP_S_W-1:0] em1;
  logic signed [EXP_S_W-1:0] need_x;
  logic signed [EXP_S_W-1:0] neg;
  logic signed [EXP_S_W-1:0] expo_fix;
  logic                      do_left;
  logic                      enough;
  logic                      shl_next;
  logic [SHW-1:0]            amt_next;
  logic [EXP_U_W-1:0]        expo_next;

  assign expo_s  = {expo_in[EXP_IN_W-1], expo_in};
  assign em1     = expo_s - ONE;
  assign need_x  = EXP_S_W'(need_in);
  assign neg     = ZERO - expo_s;
  assign do_left = (lead_in == 2'd0) && (expo_s > ONE);
  assign enough  = em1 >= need_x;

  always_comb begin
    expo_fix = expo_s;
    if (do_left) begin
      // Left shift stops at the leading one or when the exponent reaches one;
      // in the latter case the value is denormal and the exponent becomes zero.
      shl_next  = 1'b1;
      amt_next  = enough ? SHW'(need_in) : em1[SHW-1:0];
      expo_next = enough ? EXP_U_W'(expo_s - need_x) : '0;
    end else if (expo_s < ZERO) begin
      shl_next  = 1'b0;
      amt_next  = (neg >= MAG_X) ? SHW'(MAG_W) : neg[SHW-1:0];
      expo_next = '0;
    end else begin
      if (expo_s == ZERO && lead_in != 2'd0) begin
        expo_fix = ONE;
      end else if (expo_s == ONE && lead_in == 2'd0) begin
        expo_fix = ZERO;
      end
      // A carry into the upper integer bit costs one right shift.
      shl_next  = 1'b0;
      amt_next  = SHW'(lead_in[1]);
      expo_next = EXP_U_W'(expo_fix) + EXP_U_W'(lead_in[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl  <= ctl_in;
      expo <= expo_next;
      mag  <= {lead_in, low_in};
      shl  <= shl_next;
      amt  <= amt_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/idnr_shift.sv
// Stage 3: barrel shifter. Left shifts fill with the sticky bit; right shifts fold
// every bit shifted out into the sticky bit. Uses idnr_pkg.
`default_nettype none

module idnr_shift #(
  parameter int FRACTION_BITS = idnr_pkg::FRACTION_BITS_DEF,
  parameter int ROUND_BITS    = idnr_pkg::ROUND_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  idnr_pkg::idnr_ctl_t                 ctl_in,
  input  logic [idnr_pkg::EXP_U_W-1:0]        expo_in,
  input  logic [FRACTION_BITS+ROUND_BITS+1:0] mag_in,
  input  logic                                shl_in,
  input  logic [$clog2(FRACTION_BITS+ROUND_BITS+3)-1:0] amt_in,
  output idnr_pkg::idnr_ctl_t                 ctl,
  output logic [idnr_pkg::EXP_U_W-1:0]        expo,
  output logic [1:0]                          lead,
  output logic [FRACTION_BITS-1:0]            frac,
  output logic [ROUND_BITS-1:0]               rnd
);
  import idnr_pkg::*;

  localparam int MAG_W = FRACTION_BITS + ROUND_BITS + 2;

  logic [MAG_W-1:0] low_mask;
  logic [MAG_W-1:0] left;
  logic [MAG_W-1:0] right_raw;
  logic [MAG_W-1:0] result;

  // A shift by the full width clears the shifted ones, so the mask covers every bit.
  assign low_mask  = ~({MAG_W{1'b1}} << amt_in);
  assign left      = (mag_in << amt_in) | (mag_in[0] ? low_mask : '0);
  assign right_raw = mag_in >> amt_in;
  assign result    = shl_in ? left
                            : {right_raw[MAG_W-1:1], right_raw[0] | (|(mag_in & low_mask))};

  always_ff @(posedge clk) begin
    if (en) begin
      ctl  <= ctl_in;
      expo <= expo_in;
      lead <= result[MAG_W-1:MAG_W-2];
      frac <= result[FRACTION_BITS+ROUND_BITS-1:ROUND_BITS];
      rnd  <= result[ROUND_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/idnr_round.sv
// Stage 4: rounding, renormalization after a rounding carry, overflow and underflow
// handling, and the output register. Uses idnr_pkg.
`default_nettype none

module idnr_round #(
  parameter int FRACTION_BITS = idnr_pkg::FRACTION_BITS_DEF,
  parameter int ROUND_BITS    = idnr_pkg::ROUND_BITS_DEF,
  parameter int MAX_EXPONENT  = idnr_pkg::MAX_EXPONENT_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  idnr_pkg::round_mode_t             round_mode,
  input  idnr_pkg::underflow_mode_t         underflow_mode,
  input  idnr_pkg::idnr_ctl_t               ctl_in,
  input  logic [idnr_pkg::EXP_U_W-1:0]      expo_in,
  input  logic [1:0]                        lead_in,
  input  logic [FRACTION_BITS-1:0]          frac_in,
  input  logic [ROUND_BITS-1:0]             rnd_in,
  output logic                              sign_out,
  output logic [idnr_pkg::EXP_OUT_W-1:0]    exponent_out,
  output logic [FRACTION_BITS-1:0]          fraction_out,
  output idnr_pkg::idnr_flags_t             flags
);
  import idnr_pkg::*;

  localparam int SUM_W = FRACTION_BITS + 2;

  logic                     up;
  logic [SUM_W-1:0]         sum;
  logic [1:0]               lead_r;
  logic [FRACTION_BITS-1:0] frac_r;
  logic                     lead_f;
  logic [FRACTION_BITS-1:0] frac_f;
  logic [ROUND_BITS-1:0]    rnd_f;
  logic [EXP_U_W-1:0]       expo_f;
  logic                     mag_zero;
  logic                     sign_next;
  logic [EXP_OUT_W-1:0]     exp_next;
  logic [FRACTION_BITS-1:0] frac_next;
  idnr_flags_t              flags_next;

  always_comb begin
    unique case (round_mode)
      RM_TOWARD_POS:  up = (|rnd_in) && !ctl_in.sign;
      RM_TOWARD_NEG:  up = (|rnd_in) && ctl_in.sign;
      RM_TOWARD_ZERO: up = 1'b0;
      default:        up = rnd_in[ROUND_BITS-1] && ((|rnd_in[ROUND_BITS-2:0]) || frac_in[0]);
    endcase

    // The integer part is at most one here.
    sum    = {1'b0, lead_in[0], frac_in} + SUM_W'(up);
    lead_r = sum[SUM_W-1:FRACTION_BITS];
    frac_r = sum[FRACTION_BITS-1:0];

    if (lead_r[1]) begin
      // Rounding carried into a new integer bit; the old sticky bit is dropped here.
      lead_f = 1'b1;
      frac_f = {lead_r[0], frac_r[FRACTION_BITS-1:1]};
      rnd_f  = {frac_r[0], rnd_in[ROUND_BITS-1:1]};
      expo_f = expo_in + EXP_U_W'(1);
    end else begin
      lead_f = lead_r[0];
      frac_f = frac_r;
      rnd_f  = rnd_in;
      if (!lead_r[0]) begin
        expo_f = '0;
      end else if (expo_in == '0) begin
        expo_f = EXP_U_W'(1);
      end else begin
        expo_f = expo_in;
      end
    end
    mag_zero = !lead_f && (frac_f == '0);

    sign_next           = ctl_in.sign;
    flags_next.negative = ctl_in.sign;
    if (ctl_in.is_zero) begin
      exp_next             = '0;
      frac_next            = '0;
      flags_next.zero      = 1'b1;
      flags_next.underflow = 1'b0;
      flags_next.overflow  = 1'b0;
      flags_next.inexact   = 1'b0;
    end else if (expo_f > EXP_U_W'(MAX_EXPONENT)) begin
      exp_next             = EXP_OUT_W'(MAX_EXPONENT + 1);
      frac_next            = '0;
      flags_next.zero      = mag_zero;
      flags_next.underflow = mag_zero;
      flags_next.overflow  = 1'b1;
      flags_next.inexact   = 1'b0;
    end else if (expo_f == '0 && underflow_mode != UF_KEEP && frac_f != '0) begin
      if (underflow_mode == UF_FLUSH_POS) begin
        sign_next = 1'b0;
      end
      exp_next             = (underflow_mode == UF_SIGNED_TINY) ? EXP_OUT_W'(1) : '0;
      frac_next            = '0;
      flags_next.zero      = 1'b1;
      flags_next.underflow = 1'b1;
      flags_next.overflow  = 1'b0;
      flags_next.inexact   = |rnd_f;
    end else begin
      exp_next             = expo_f[EXP_OUT_W-1:0];
      frac_next            = frac_f;
      flags_next.zero      = mag_zero;
      flags_next.underflow = mag_zero;
      flags_next.overflow  = 1'b0;
      flags_next.inexact   = |rnd_f;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sign_out     <= sign_next;
      exponent_out <= exp_next;
      fraction_out <= frac_next;
      flags        <= flags_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/idnr_checker.sv
// Port-level assertions for the binary64 normalize-and-round pipeline, attached to the
// top level by the bind statement at the end of this file. Uses idnr_pkg.
`default_nettype none

module idnr_checker #(
  parameter int FRACTION_BITS = idnr_pkg::FRACTION_BITS_DEF
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 sign_out,
  input logic [idnr_pkg::EXP_OUT_W-1:0]       exponent_out,
  input logic [FRACTION_BITS-1:0]             fraction_out,
  input logic                                 flag_negative,
  input logic                                 flag_zero,
  input logic                                 flag_underflow,
  input logic                                 flag_overflow,
  input logic                                 flag_inexact
);
  import idnr_pkg::*;

  // A stalled result stays offered, with its sign, exponent and fraction unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sign_out) && $stable(exponent_out)
      && $stable(fraction_out))
    else $error("result withdrawn or changed while stalled");

  // Every accepted item is visible at the output once it has passed all stage registers, or the
  // output register is occupied by an earlier item.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> ##4 out_valid)
    else $error("pipeline did not deliver within its latency");

  // With the output register empty nothing can block the input.
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty pipeline");

  // The result sign differs from the input sign only on a flush to plus zero.
  a_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && (sign_out != flag_negative) |-> flag_zero && flag_underflow && !sign_out)
    else $error("sign changed without a flush to plus zero");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && flag_overflow |-> (fraction_out == '0) && !flag_inexact && !flag_zero)
    else $error("overflow result is not a clean infinity");

endmodule

bind ieee_double_normalize_round idnr_checker #(
  .FRACTION_BITS(FRACTION_BITS)
) u_idnr_checker (.*);

`default_nettype wire
